/* rtl/core/qbez_pkg.sv */
// ----------------------------------------------------------------------------
// qbez_pkg
// Shared constants, register map and controller-to-datapath command bundle
// for the quadratic Bezier point generator.
// ----------------------------------------------------------------------------
`default_nettype none

package qbez_pkg;

  // Default widths
  localparam int COORD_WIDTH_DEF     = 16;
  localparam int PARAM_FRAC_BITS_DEF = 16;

  // Step register value after reset (about 0.01 in Q1.16)
  localparam int STEP_RESET = 655;

  // Register map
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_A_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_A_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_B_X  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_B_Y  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_C_X  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_C_Y  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_STEP = 3'd6;

  // Axis lanes
  localparam int AXIS_X = 0;
  localparam int AXIS_Y = 1;
  localparam int NUM_AXES = 2;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;    // accept a tick: latch t, advance the parameter
    logic mul_ab;  // product <= (b - a) * t
    logic mul_bc;  // p <= a + round(product); product <= (c - b) * t
    logic lat_q;   // q <= b + round(product)
    logic mul_pq;  // product <= (q - p) * t
    logic lat_r;   // output <= p + round(product)
  } dp_cmd_t;

endpackage

`default_nettype wire

/* rtl/core/qbez_ctrl.sv */
// ----------------------------------------------------------------------------
// qbez_ctrl
// Sequencer for one curve point: steps the datapath through the three
// interpolation levels and owns the input and output handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module qbez_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output      logic              in_stall,
  output      logic              out_valid,
  input  wire logic              out_stall,
  output      qbez_pkg::dp_cmd_t cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MAB  = 3'd1;
  localparam logic [2:0] ST_MBC  = 3'd2;
  localparam logic [2:0] ST_LQ   = 3'd3;
  localparam logic [2:0] ST_MPQ  = 3'd4;
  localparam logic [2:0] ST_LR   = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_MAB;
        end
      end
      ST_MAB: begin
        cmd.mul_ab = 1'b1;
        state_nxt  = ST_MBC;
      end
      ST_MBC: begin
        cmd.mul_bc = 1'b1;
        state_nxt  = ST_LQ;
      end
      ST_LQ: begin
        cmd.lat_q = 1'b1;
        state_nxt = ST_MPQ;
      end
      ST_MPQ: begin
        cmd.mul_pq = 1'b1;
        state_nxt  = ST_LR;
      end
      ST_LR: begin
        // hold the last step until the output register is free
        if (!out_valid_r || !out_stall) begin
          cmd.lat_r = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output valid: set on a new result, cleared on transfer
  assign out_valid_nxt = cmd.lat_r | (out_valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

/* rtl/core/qbez_dp.sv */
// ----------------------------------------------------------------------------
// qbez_dp
// Datapath: configuration registers, curve parameter, one multiplier per
// axis with a registered product, interpolation registers and output
// payload register.
// ----------------------------------------------------------------------------
`default_nettype none

module qbez_dp #(
  parameter int COORD_WIDTH     = qbez_pkg::COORD_WIDTH_DEF,
  parameter int PARAM_FRAC_BITS = qbez_pkg::PARAM_FRAC_BITS_DEF,
  parameter int CFG_DATA_W      = (COORD_WIDTH > PARAM_FRAC_BITS + 1) ?
                                  COORD_WIDTH : PARAM_FRAC_BITS + 1
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [qbez_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [CFG_DATA_W-1:0]               cfg_data,
  input  wire logic                                in_restart,
  input  wire qbez_pkg::dp_cmd_t                   cmd,
  output      logic signed [COORD_WIDTH-1:0]       out_point_x,
  output      logic signed [COORD_WIDTH-1:0]       out_point_y,
  output      logic [PARAM_FRAC_BITS:0]            out_param_used,
  output      logic                                out_last
);

  localparam int CW    = COORD_WIDTH;
  localparam int F     = PARAM_FRAC_BITS;
  localparam int PW    = F + 1;
  localparam int PRODW = CW + PW + 2;
  localparam int NA    = qbez_pkg::NUM_AXES;

  localparam logic [PW-1:0]    PARAM_ONE = {1'b1, {F{1'b0}}};
  localparam logic [PW-1:0]    STEP_RST  = PW'(qbez_pkg::STEP_RESET);
  localparam logic [PRODW-1:0] HALF      = PRODW'(1) << (F - 1);

  // Configuration
  logic [CW-1:0] a_r [NA];
  logic [CW-1:0] b_r [NA];
  logic [CW-1:0] c_r [NA];
  logic [PW-1:0] step_r;

  // Curve state and per-point registers
  logic [PW-1:0] param_r;
  logic [PW-1:0] t_r;
  logic          last_r;

  logic [CW-1:0]           p_r    [NA];
  logic [CW-1:0]           q_r    [NA];
  logic signed [PRODW-1:0] prod_r [NA];

  logic signed [CW-1:0] pt_x_r, pt_y_r;
  logic [PW-1:0]        pt_t_r;
  logic                 pt_last_r;

  // Parameter advance
  logic [PW-1:0] t0;
  logic [PW-1:0] t_clamp;
  logic [PW:0]   t_next;
  logic          last_nxt;

  always_comb begin
    t0       = in_restart ? '0 : param_r;
    t_clamp  = (t0 > PARAM_ONE) ? PARAM_ONE : t0;
    t_next   = {1'b0, t_clamp} + {1'b0, step_r};
    last_nxt = (t_next > {1'b0, PARAM_ONE});
  end

  // Operand select, multiply and rounding for each axis lane
  logic [CW-1:0]           op_hi   [NA];
  logic [CW-1:0]           op_lo   [NA];
  logic signed [CW:0]      diff    [NA];
  logic signed [PRODW-1:0] prod_nxt[NA];
  logic signed [PRODW-1:0] rsum    [NA];
  logic signed [PRODW-1:0] rshift  [NA];
  logic [CW-1:0]           base    [NA];
  logic [CW-1:0]           lerp    [NA];
  logic signed [PW:0]      t_ext;

  assign t_ext = $signed({1'b0, t_r});

  always_comb begin
    for (int i = 0; i < NA; i++) begin
      if (cmd.mul_ab) begin
        op_hi[i] = b_r[i];
        op_lo[i] = a_r[i];
      end else if (cmd.mul_bc) begin
        op_hi[i] = c_r[i];
        op_lo[i] = b_r[i];
      end else begin
        op_hi[i] = q_r[i];
        op_lo[i] = p_r[i];
      end
      diff[i]     = $signed({op_hi[i][CW-1], op_hi[i]}) - $signed({op_lo[i][CW-1], op_lo[i]});
      prod_nxt[i] = diff[i] * t_ext;

      // base + floor((product + half) / one)
      if (cmd.mul_bc) begin
        base[i] = a_r[i];
      end else if (cmd.lat_q) begin
        base[i] = b_r[i];
      end else begin
        base[i] = p_r[i];
      end
      rsum[i]   = prod_r[i] + $signed(HALF);
      rshift[i] = rsum[i] >>> F;
      lerp[i]   = base[i] + rshift[i][CW-1:0];
    end
  end

  // Configuration registers and curve parameter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NA; i++) begin
        a_r[i] <= '0;
        b_r[i] <= '0;
        c_r[i] <= '0;
      end
      step_r  <= STEP_RST;
      param_r <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          qbez_pkg::REG_A_X:  a_r[qbez_pkg::AXIS_X] <= cfg_data[CW-1:0];
          qbez_pkg::REG_A_Y:  a_r[qbez_pkg::AXIS_Y] <= cfg_data[CW-1:0];
          qbez_pkg::REG_B_X:  b_r[qbez_pkg::AXIS_X] <= cfg_data[CW-1:0];
          qbez_pkg::REG_B_Y:  b_r[qbez_pkg::AXIS_Y] <= cfg_data[CW-1:0];
          qbez_pkg::REG_C_X:  c_r[qbez_pkg::AXIS_X] <= cfg_data[CW-1:0];
          qbez_pkg::REG_C_Y:  c_r[qbez_pkg::AXIS_Y] <= cfg_data[CW-1:0];
          qbez_pkg::REG_STEP: step_r <= cfg_data[PW-1:0];
          default: ;
        endcase
      end
      if (cmd.load) begin
        param_r <= last_nxt ? '0 : t_next[PW-1:0];
      end
    end
  end

  // Per-point working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      t_r    <= t_clamp;
      last_r <= last_nxt;
    end
    for (int i = 0; i < NA; i++) begin
      if (cmd.mul_ab || cmd.mul_bc || cmd.mul_pq) begin
        prod_r[i] <= prod_nxt[i];
      end
      if (cmd.mul_bc) begin
        p_r[i] <= lerp[i];
      end
      if (cmd.lat_q) begin
        q_r[i] <= lerp[i];
      end
    end
  end

  // Output payload register
  always_ff @(posedge clk) begin
    if (cmd.lat_r) begin
      pt_x_r    <= $signed(lerp[qbez_pkg::AXIS_X]);
      pt_y_r    <= $signed(lerp[qbez_pkg::AXIS_Y]);
      pt_t_r    <= t_r;
      pt_last_r <= last_r;
    end
  end

  assign out_point_x    = pt_x_r;
  assign out_point_y    = pt_y_r;
  assign out_param_used = pt_t_r;
  assign out_last       = pt_last_r;

endmodule

`default_nettype wire

/* rtl/core/quadratic_bezier_point_generator_core.sv */
// ----------------------------------------------------------------------------
// quadratic_bezier_point_generator_core
// Quadratic Bezier point generator, de Casteljau form: each tick yields one
// curve point at the current parameter, which then advances by the step, or to zero after the last point.
//
//   Channel | Direction | Handshake          | Payload
//   --------+-----------+--------------------+------------------------------
//   cfg     | in        | cfg_we             | cfg_index, cfg_data
//   in      | in        | in_valid/in_stall  | in_restart
//   out     | out       | out_valid/out_stall| out_point_x/y, param_used, last
//
// One point takes the accept cycle and five steps of the sequencer through
// the three interpolation levels on one multiplier per axis.
// in_stall is high from the cycle after a transfer until the point is in the
// output register; a new tick is then taken while that result waits.
// A stalled output holds the last step; nothing is lost or repeated.
// Reset is synchronous, active low; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module quadratic_bezier_point_generator_core #(
  parameter int COORD_WIDTH     = qbez_pkg::COORD_WIDTH_DEF,
  parameter int PARAM_FRAC_BITS = qbez_pkg::PARAM_FRAC_BITS_DEF,
  parameter int CFG_DATA_W      = (COORD_WIDTH > PARAM_FRAC_BITS + 1) ?
                                  COORD_WIDTH : PARAM_FRAC_BITS + 1
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // configuration
  input  wire logic                           cfg_we,
  input  wire logic [qbez_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]          cfg_data,
  // ticks
  input  wire logic                           in_valid,
  output      logic                           in_stall,
  input  wire logic                           in_restart,
  // points
  output      logic                           out_valid,
  input  wire logic                           out_stall,
  output      logic signed [COORD_WIDTH-1:0]  out_point_x,
  output      logic signed [COORD_WIDTH-1:0]  out_point_y,
  output      logic [PARAM_FRAC_BITS:0]       out_param_used,
  output      logic                           out_last
);

  qbez_pkg::dp_cmd_t cmd;

  // Sequencer
  qbez_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // Datapath
  qbez_dp #(
    .COORD_WIDTH     (COORD_WIDTH),
    .PARAM_FRAC_BITS (PARAM_FRAC_BITS),
    .CFG_DATA_W      (CFG_DATA_W)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_restart     (in_restart),
    .cmd            (cmd),
    .out_point_x    (out_point_x),
    .out_point_y    (out_point_y),
    .out_param_used (out_param_used),
    .out_last       (out_last)
  );

`ifndef SYNTHESIS
  localparam logic [PARAM_FRAC_BITS:0] PARAM_ONE = {1'b1, {PARAM_FRAC_BITS{1'b0}}};

  // a tick transfer starts a point: no second tick in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("tick taken while a point is in progress");

  // a new result appears only from the final interpolation step
  a_valid_from_last_step: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(cmd.lat_r))
    else $error("output valid without a final step");

  // the reported parameter never exceeds one
  a_param_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_param_used <= PARAM_ONE)
    else $error("parameter above one");

  // the datapath gets at most one command per cycle
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd))
    else $error("conflicting datapath commands");
`endif

endmodule

`default_nettype wire

/* dv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the quadratic Bezier point generator. A directed
// table covers reset values, coordinate extremes, zero, unit and oversized
// steps, wide register data and the unused register index. Random phases
// follow; each loads a step, mostly new control points, then a tick burst.
// Each point is checked per field against a de Casteljau model or table row.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

  localparam int CW = 16;
  localparam int PF = 16;
  localparam int CFG_W = 17;
  localparam int IDX_W = qbez_pkg::CFG_IDX_W;
  localparam logic [PF:0] PARAM_ONE = 17'h10000;
  localparam logic [CW-1:0] SIGN_BIT = 16'h8000;
  localparam logic [IDX_W-1:0] REG_NONE = 3'd7;   // not decoded by the block
  localparam int RANDOM_TICKS = 900;
  localparam int RX_HOLD_CYCLES = 150;
  localparam int STUCK_LIMIT = 2000;
  localparam int TAIL_CYCLES = 12;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic [PF:0]          param;
    logic                 last;
  } point_t;

  typedef enum logic {ROW_WRITE, ROW_TICK} row_kind_t;

  typedef struct {
    row_kind_t          kind;
    logic [IDX_W-1:0]   idx;
    logic [CFG_W-1:0]   data;
    logic               restart;
    logic               pinned;
    point_t             pt;
  } stim_row_t;

  // DUT connections; the inputs are known from time zero
  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [IDX_W-1:0]       cfg_index = '0;
  logic [CFG_W-1:0]       cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic                   in_restart = 1'b0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic signed [CW-1:0]   out_point_x;
  logic signed [CW-1:0]   out_point_y;
  logic [PF:0]            out_param_used;
  logic                   out_last;

  // typed expectation that travels with a tick transfer
  logic                   row_pinned = 1'b0;
  point_t                 row_exp = '0;

  // curve model state
  logic [CW-1:0]          ctl_reg [6];
  logic [PF:0]            step_reg;
  logic [PF:0]            t_cur;

  point_t                 pending_points [$];
  stim_row_t              stim_rows [$];

  int  ticks_sent = 0;
  int  restarts_sent = 0;
  int  points_seen = 0;
  int  curve_ends = 0;
  int  writes_done = 0;
  int  settings_used = 0;
  int  mismatches = 0;
  int  stuck_cycles = 0;
  bit  hold_rx = 1'b0;
  bit  quiet = 1'b0;

  quadratic_bezier_point_generator_core u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_restart     (in_restart),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_point_x    (out_point_x),
    .out_point_y    (out_point_y),
    .out_param_used (out_param_used),
    .out_last       (out_last)
  );

  always #1 clk = ~clk;

  // --------------------------------------------------------------------------
  // Curve model
  // --------------------------------------------------------------------------

  // round-half-up interpolation on offset-binary coordinates
  function automatic logic [CW-1:0] lerp_offset(logic [CW-1:0] p, logic [CW-1:0] q,
                                                logic [PF:0] t);
    logic [63:0] acc;
    acc = 64'(p) * (64'(PARAM_ONE) - 64'(t)) + 64'(q) * 64'(t) + 64'(PARAM_ONE >> 1);
    return acc[PF +: CW];
  endfunction

  function automatic logic [CW-1:0] axis_point(logic [CW-1:0] a, logic [CW-1:0] b,
                                               logic [CW-1:0] c, logic [PF:0] t);
    logic [CW-1:0] p;
    logic [CW-1:0] q;
    p = lerp_offset(a ^ SIGN_BIT, b ^ SIGN_BIT, t);
    q = lerp_offset(b ^ SIGN_BIT, c ^ SIGN_BIT, t);
    return lerp_offset(p, q, t) ^ SIGN_BIT;
  endfunction

  function automatic void apply_write(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    if (idx <= qbez_pkg::REG_C_Y) begin
      ctl_reg[idx] = data[CW-1:0];
    end else if (idx == qbez_pkg::REG_STEP) begin
      step_reg = data[PF:0];
    end
  endfunction

  // point for one tick; advances the parameter and wraps after the last point
  function automatic point_t next_curve_point(logic restart);
    point_t      pt;
    logic [PF:0] t;
    logic [PF+1:0] nxt;
    if (restart) t_cur = '0;
    t = (t_cur > PARAM_ONE) ? PARAM_ONE : t_cur;
    pt.x = axis_point(ctl_reg[qbez_pkg::REG_A_X], ctl_reg[qbez_pkg::REG_B_X],
                      ctl_reg[qbez_pkg::REG_C_X], t);
    pt.y = axis_point(ctl_reg[qbez_pkg::REG_A_Y], ctl_reg[qbez_pkg::REG_B_Y],
                      ctl_reg[qbez_pkg::REG_C_Y], t);
    pt.param = t;
    nxt = {1'b0, t} + {1'b0, step_reg};
    pt.last = nxt > {1'b0, PARAM_ONE};
    t_cur = pt.last ? '0 : nxt[PF:0];
    return pt;
  endfunction

  // --------------------------------------------------------------------------
  // Monitor: model update on each transfer, point check on each output
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    point_t want;
    if (rst_n && cfg_we) apply_write(cfg_index, cfg_data);
    if (rst_n && in_valid && !in_stall) begin
      want = next_curve_point(in_restart);
      pending_points.insert(pending_points.size(), row_pinned ? row_exp : want);
    end
    if (rst_n && out_valid && !out_stall) begin
      points_seen++;
      if (pending_points.size() == 0) begin
        $error("point with nothing pending: x %0d y %0d param %0d last %0b",
               out_point_x, out_point_y, out_param_used, out_last);
        mismatches++;
      end else begin
        want = pending_points.pop_front();
        if (want.last) curve_ends++;
        if (out_point_x !== want.x) begin
          $error("point_x: expected %0d, got %0d", $signed(want.x), out_point_x);
          mismatches++;
        end
        if (out_point_y !== want.y) begin
          $error("point_y: expected %0d, got %0d", $signed(want.y), out_point_y);
          mismatches++;
        end
        if (out_param_used !== want.param) begin
          $error("param_used: expected %0d, got %0d", want.param, out_param_used);
          mismatches++;
        end
        if (out_last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, out_last);
          mismatches++;
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("no transfer for %0d cycles", STUCK_LIMIT);
      $display("FAILURE");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // receiver: random stalls, one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_rx) begin
        out_stall <= 1'b1;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        hold_rx = 1'b0;
      end
      out_stall <= quiet ? 1'b0 : ($urandom_range(99) < 16);
    end
  end

  // --------------------------------------------------------------------------
  // Sender tasks
  // --------------------------------------------------------------------------
  task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    writes_done++;
  endtask

  // hold ticks back until every point has come out
  task automatic drain();
    if (in_valid) in_valid <= 1'b0;
    while (points_seen != ticks_sent) @(posedge clk);
  endtask

  task automatic send_tick(logic restart, logic pin, point_t pt);
    cfg_we <= 1'b0;
    if (!quiet && $urandom_range(99) < 16) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 16);
    end
    in_valid   <= 1'b1;
    in_restart <= restart;
    row_pinned <= pin;
    row_exp    <= pt;
    do @(posedge clk); while (in_stall);
    ticks_sent++;
    if (restart) restarts_sent++;
  endtask

  function automatic void add_write(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    stim_row_t row;
    row.kind = ROW_WRITE;
    row.idx = idx;
    row.data = data;
    row.restart = 1'b0;
    row.pinned = 1'b0;
    row.pt = '0;
    stim_rows.insert(stim_rows.size(), row);
  endfunction

  function automatic void add_tick(logic restart);
    stim_row_t row;
    row.kind = ROW_TICK;
    row.idx = '0;
    row.data = '0;
    row.restart = restart;
    row.pinned = 1'b0;
    row.pt = '0;
    stim_rows.insert(stim_rows.size(), row);
  endfunction

  function automatic void add_point(logic restart, int x, int y, int param, logic last);
    stim_row_t row;
    row.kind = ROW_TICK;
    row.idx = '0;
    row.data = '0;
    row.restart = restart;
    row.pinned = 1'b1;
    row.pt.x = CW'(x);
    row.pt.y = CW'(y);
    row.pt.param = 17'(param);
    row.pt.last = last;
    stim_rows.insert(stim_rows.size(), row);
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : main
    logic [CFG_W-1:0] data;
    int burst;
    int phase;
    int first_random;
    int one;

    for (int i = 0; i < 6; i++) ctl_reg[i] = '0;
    step_reg = 17'(qbez_pkg::STEP_RESET);
    t_cur = '0;
    one = int'(PARAM_ONE);

    // directed table
    add_point(1'b0, 0, 0, 0, 1'b0);                 // reset values
    add_point(1'b0, 0, 0, qbez_pkg::STEP_RESET, 1'b0);
    add_point(1'b1, 0, 0, 0, 1'b0);
    add_write(qbez_pkg::REG_A_X, 17'h07FFF);        // all points at the extremes
    add_write(qbez_pkg::REG_A_Y, 17'h08000);
    add_write(qbez_pkg::REG_B_X, 17'h07FFF);
    add_write(qbez_pkg::REG_B_Y, 17'h08000);
    add_write(qbez_pkg::REG_C_X, 17'h07FFF);
    add_write(qbez_pkg::REG_C_Y, 17'h08000);
    add_point(1'b1, 32767, -32768, 0, 1'b0);
    add_point(1'b0, 32767, -32768, qbez_pkg::STEP_RESET, 1'b0);
    add_write(qbez_pkg::REG_A_X, 17'h08000);        // step of exactly one
    add_write(qbez_pkg::REG_A_Y, 17'h07FFF);
    add_write(qbez_pkg::REG_B_X, 17'h03039);
    add_write(qbez_pkg::REG_B_Y, 17'h0FCF7);
    add_write(qbez_pkg::REG_C_X, 17'h07FFF);
    add_write(qbez_pkg::REG_C_Y, 17'h08000);
    add_write(qbez_pkg::REG_STEP, 17'h10000);
    add_point(1'b1, -32768, 32767, 0, 1'b0);
    add_point(1'b0, 32767, -32768, one, 1'b1);
    add_point(1'b0, -32768, 32767, 0, 1'b0);
    add_write(qbez_pkg::REG_STEP, 17'h08000);       // half step, t starts at one
    add_point(1'b0, 32767, -32768, one, 1'b1);
    add_point(1'b0, -32768, 32767, 0, 1'b0);
    add_tick(1'b0);
    add_point(1'b0, 32767, -32768, one, 1'b1);
    add_write(qbez_pkg::REG_STEP, 17'h00000);       // zero step repeats the point
    add_point(1'b1, -32768, 32767, 0, 1'b0);
    add_point(1'b0, -32768, 32767, 0, 1'b0);
    add_write(qbez_pkg::REG_STEP, 17'h1FFFF);       // step above one: always last
    add_point(1'b0, -32768, 32767, 0, 1'b1);
    add_point(1'b0, -32768, 32767, 0, 1'b1);
    add_write(qbez_pkg::REG_STEP, 17'h00001);       // smallest step
    add_point(1'b1, -32768, 32767, 0, 1'b0);
    add_tick(1'b0);
    add_write(qbez_pkg::REG_A_X, 17'h10005);        // bit 16 dropped on coordinates
    add_write(qbez_pkg::REG_A_Y, 17'h1FFF0);
    add_write(REG_NONE, 17'h00000);                 // unused index changes nothing
    add_point(1'b1, 5, -16, 0, 1'b0);
    add_tick(1'b0);
    add_tick(1'b0);
    add_write(qbez_pkg::REG_B_X, 17'h0B1E0);        // general curve
    add_write(qbez_pkg::REG_B_Y, 17'h07530);
    add_write(qbez_pkg::REG_C_X, 17'h003E8);
    add_write(qbez_pkg::REG_C_Y, 17'h1FC18);
    add_write(qbez_pkg::REG_STEP, 17'h0199A);
    add_tick(1'b0);
    add_tick(1'b0);
    add_tick(1'b1);
    add_tick(1'b0);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (stim_rows[i]) begin
      if (stim_rows[i].kind == ROW_WRITE) begin
        drain();
        write_reg(stim_rows[i].idx, stim_rows[i].data);
      end else begin
        send_tick(stim_rows[i].restart, stim_rows[i].pinned, stim_rows[i].pt);
      end
    end
    settings_used = 7;

    // random phases: new step, mostly a new curve, then a burst of ticks
    first_random = ticks_sent;
    phase = 0;
    while (ticks_sent - first_random < RANDOM_TICKS) begin
      drain();
      if (phase == 0 || $urandom_range(3) != 0) begin
        for (int r = int'(qbez_pkg::REG_A_X); r <= int'(qbez_pkg::REG_C_Y); r++) begin
          case ($urandom_range(7))
            0:       data = 17'h07FFF;
            1:       data = 17'h08000;
            2:       data = 17'h00000;
            3:       data = 17'h0FFFF;
            default: data = 17'($urandom);
          endcase
          data[CFG_W-1] = 1'($urandom_range(1));
          write_reg(r[IDX_W-1:0], data);
        end
      end
      if ($urandom_range(7) == 0) write_reg(REG_NONE, 17'($urandom));
      case ($urandom_range(9))
        0:       data = 17'h00000;
        1:       data = 17'h00001;
        2:       data = 17'h10000;
        3:       data = 17'($urandom_range(17'h10001, 17'h1FFFF));
        4, 5, 6: data = 17'($urandom_range(2000, 20000));
        default: data = 17'($urandom_range(1, 17'h10000));
      endcase
      write_reg(qbez_pkg::REG_STEP, data);
      settings_used++;

      hold_rx = (phase == 4);
      quiet = (phase >= 8 && phase < 12);
      burst = $urandom_range(15, 50);
      repeat (burst) send_tick($urandom_range(99) < 4, 1'b0, '0);
      phase++;
    end
    quiet = 1'b0;

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d ticks (%0d restarts) over %0d curve settings, %0d register writes;",
             ticks_sent, restarts_sent, settings_used, writes_done);
    $display("checked %0d points, %0d curve ends, %0d mismatching fields.",
             points_seen, curve_ends, mismatches);
    if (mismatches == 0 && pending_points.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* sim.f */
rtl/core/qbez_pkg.sv
rtl/core/qbez_ctrl.sv
rtl/core/qbez_dp.sv
rtl/core/quadratic_bezier_point_generator_core.sv
dv/tb_top.sv
